FILE: rtl/alsp_pkg.sv
// ----------------------------------------------------------------------------
// alsp_pkg
// Shared types and constants for the adaptive load sampling profiler.
// ----------------------------------------------------------------------------
`default_nettype none

package alsp_pkg;

    localparam int CFG_W    = 40;   // widest configuration register
    localparam int CFG_IX_W = 3;
    localparam int WIDE_W   = 96;   // product and dividend width
    localparam int MUL_A_W  = 64;
    localparam int MUL_B_W  = 40;
    localparam int MUL_N_W  = 6;
    localparam int DIV_D_W  = 64;
    localparam int DIV_Q_W  = 32;
    localparam int DIV_N_W  = 7;

    localparam logic [19:0] MICRO = 20'd1000000;

    localparam logic [CFG_IX_W-1:0] REG_CAPACITY = 3'd0;
    localparam logic [CFG_IX_W-1:0] REG_TARGET   = 3'd1;
    localparam logic [CFG_IX_W-1:0] REG_TICK     = 3'd2;
    localparam logic [CFG_IX_W-1:0] REG_MAX_PER  = 3'd3;
    localparam logic [CFG_IX_W-1:0] REG_LOW_THR  = 3'd4;
    localparam logic [CFG_IX_W-1:0] REG_START_EL = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_D1,
        S_MUL_P1,
        S_DIV1,
        S_PERIOD,
        S_MUL_T,
        S_MUL_P2,
        S_DIV2,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/alsp_mul.sv
// ----------------------------------------------------------------------------
// alsp_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module alsp_mul (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [alsp_pkg::MUL_A_W-1:0]  a,
    input  wire logic [alsp_pkg::MUL_B_W-1:0]  b,
    input  wire logic [alsp_pkg::MUL_N_W-1:0]  nbits,
    output logic                               done,
    output logic [alsp_pkg::WIDE_W-1:0]        prod
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [alsp_pkg::MUL_N_W-1:0]  cnt_reg;
    logic [alsp_pkg::WIDE_W-1:0]   acc_reg;
    logic [alsp_pkg::WIDE_W-1:0]   mcand_reg;
    logic [alsp_pkg::MUL_B_W-1:0]  mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == alsp_pkg::MUL_N_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= alsp_pkg::WIDE_W'(a);
            mplier_reg <= b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

FILE: rtl/alsp_div.sv
// ----------------------------------------------------------------------------
// alsp_div
// Restoring divider, one dividend bit per cycle, quotient with sticky overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module alsp_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [alsp_pkg::WIDE_W-1:0]   num,
    input  wire logic [alsp_pkg::DIV_D_W-1:0]  den,
    output logic                               done,
    output logic [alsp_pkg::DIV_Q_W-1:0]       quo,
    output logic                               ovf
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [alsp_pkg::DIV_N_W-1:0]  cnt_reg;
    logic [alsp_pkg::WIDE_W-1:0]   num_reg;
    logic [alsp_pkg::DIV_D_W-1:0]  den_reg;
    logic [alsp_pkg::DIV_D_W-2:0]  rem_reg;
    logic [alsp_pkg::DIV_Q_W-1:0]  quo_reg;
    logic                          ovf_reg;
    logic [alsp_pkg::DIV_D_W-1:0]  trial;
    logic [alsp_pkg::DIV_D_W-1:0]  diff;
    logic                          ge;

    // remainder stays below the divisor, which is under 2^63
    assign trial = {rem_reg, num_reg[alsp_pkg::WIDE_W-1]};
    assign diff  = trial - den_reg;
    assign ge    = (trial >= den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= alsp_pkg::DIV_N_W'(alsp_pkg::WIDE_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == alsp_pkg::DIV_N_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= ge ? diff[alsp_pkg::DIV_D_W-2:0] : trial[alsp_pkg::DIV_D_W-2:0];
            quo_reg <= {quo_reg[alsp_pkg::DIV_Q_W-2:0], ge};
            ovf_reg <= ovf_reg | quo_reg[alsp_pkg::DIV_Q_W-1];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign ovf  = ovf_reg;

endmodule

`default_nettype wire

FILE: rtl/adaptive_load_sampling_profiler.sv
// ----------------------------------------------------------------------------
// adaptive_load_sampling_profiler
// Per-tick charge accounting and adaptive sampling period computation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one signed current sample per
//   profiler tick. Output channel (out_valid / out_stall) returns one result
//   per sample: update and wakeup flags, charge fraction, interval, period.
//   The user must write configuration (cfg_we / cfg_index / cfg_wdata) only
//   while idle; the block does not enforce this. One sample at a time.
//   Charge step: a 20-bit and a 24-bit bit-serial multiply and the 96-step
//   divide; the next request is taken once the result has been loaded into
//   the output register. A sample that updates the period adds a 20-bit and
//   a 40-bit multiply and a second divide; below-threshold current skips
//   them. The first sample after reset takes only the period path.
// Reset:
//   Not started, accumulators clear, all registers at their reset values.
// Stall:
//   A finished result waits in the output register; the next sample is taken
//   meanwhile and its result holds until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_load_sampling_profiler #(
    parameter int CHARGE_FRAC_BITS = 28
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [alsp_pkg::CFG_IX_W-1:0]  cfg_index,
    input  wire logic [alsp_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [23:0]             current_ua,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                updated,
    output logic                                wakeup,
    output logic signed [31:0]                  charge_fraction,
    output logic [31:0]                         interval_us,
    output logic [31:0]                         period_us
);

    localparam logic signed [31:0] SMALL_CHARGE = 32'((64'd1 << CHARGE_FRAC_BITS) / 1000);

    alsp_pkg::state_t state_reg, state_next;

    logic [39:0]         cap_reg;
    logic [28:0]         target_reg;
    logic [31:0]         tick_reg;
    logic [31:0]         maxp_reg;
    logic [22:0]         thr_reg;

    logic                started_reg;
    logic signed [23:0]  last_current_reg;
    logic [31:0]         last_period_reg;
    logic [31:0]         last_interval_reg;
    logic signed [31:0]  charge_acc_reg;
    logic [31:0]         elapsed_reg;
    logic                upd_reg;
    logic                wake_reg;
    logic                rising_reg;
    logic                fall_reg;
    logic                out_valid_reg;

    logic                cur_neg_reg;
    logic [23:0]         mag_reg;
    logic [63:0]         d1_reg;
    logic                updated_reg;
    logic                wakeup_reg;
    logic signed [31:0]  charge_out_reg;
    logic [31:0]         interval_out_reg;
    logic [31:0]         period_out_reg;

    logic                             accept;
    logic                             out_load;
    logic [23:0]                      in_mag;
    logic [39:0]                      cap1;
    logic                             in_rising;
    logic                             in_fall;

    logic                             mul_start;
    logic [alsp_pkg::MUL_A_W-1:0]     mul_a;
    logic [alsp_pkg::MUL_B_W-1:0]     mul_b;
    logic [alsp_pkg::MUL_N_W-1:0]     mul_n;
    logic                             mul_done;
    logic [alsp_pkg::WIDE_W-1:0]      mul_prod;

    logic                             div_start;
    logic [alsp_pkg::WIDE_W-1:0]      div_num;
    logic [alsp_pkg::DIV_D_W-1:0]     div_den;
    logic                             div_done;
    logic [alsp_pkg::DIV_Q_W-1:0]     div_quo;
    logic                             div_ovf;

    logic [31:0]                      step_mag;
    logic signed [33:0]               step_s;
    logic signed [33:0]               sum_s;
    logic [32:0]                      el_sum;
    logic [31:0]                      el_c;
    logic signed [31:0]               ch_c;
    logic [31:0]                      intv_c;
    logic                             upd_c;
    logic                             low_cur;
    logic [31:0]                      period_c;

    alsp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .nbits (mul_n),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    alsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .ovf   (div_ovf)
    );

    assign accept    = in_valid && (state_reg == alsp_pkg::S_IDLE);
    assign in_stall  = (state_reg != alsp_pkg::S_IDLE);
    assign in_mag    = current_ua[23] ? (~current_ua + 24'd1) : current_ua;
    assign cap1      = (cap_reg == 40'd0) ? 40'd1 : cap_reg;
    assign in_rising = (last_current_reg < $signed({1'b0, thr_reg}))
                    && (current_ua > $signed({1'b0, thr_reg}));
    assign in_fall   = (last_current_reg > $signed({1'b0, thr_reg}))
                    && (current_ua < $signed({1'b0, thr_reg}));
    assign low_cur   = (mag_reg == 24'd0) || (mag_reg < {1'b0, thr_reg});

    // charge step, accumulator, update decisions and period clamp
    always_comb
    begin
        step_mag = (div_ovf || (div_quo > 32'h8000_0000)) ? 32'h8000_0000 : div_quo;
        step_s   = cur_neg_reg ? -$signed({2'b00, step_mag}) : $signed({2'b00, step_mag});
        sum_s    = $signed({{2{charge_acc_reg[31]}}, charge_acc_reg}) + step_s;
        el_sum   = {1'b0, elapsed_reg} + {1'b0, tick_reg};
        el_c     = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
        if (sum_s > 34'sh0_7FFF_FFFF)
            ch_c = 32'sh7FFF_FFFF;
        else if (sum_s < -34'sh0_8000_0000)
            ch_c = -32'sh8000_0000;
        else
            ch_c = sum_s[31:0];
        intv_c = last_interval_reg;
        upd_c  = 1'b0;
        if (el_c >= maxp_reg)
        begin
            if (!rising_reg)
            begin
                upd_c  = 1'b1;
                ch_c   = '0;
                intv_c = el_c;
            end
            el_c = '0;
        end
        if ($signed({ch_c[31], ch_c}) >= $signed({4'b0000, target_reg}))
        begin
            intv_c = el_c;
            ch_c   = '0;
            el_c   = '0;
            upd_c  = 1'b1;
        end
        if ((ch_c > SMALL_CHARGE) && fall_reg)
        begin
            intv_c = el_c;
            ch_c   = '0;
            el_c   = '0;
            upd_c  = 1'b1;
        end
        period_c = (div_ovf || (div_quo > maxp_reg)) ? maxp_reg : div_quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= alsp_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        mul_n      = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            alsp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (started_reg)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = alsp_pkg::MUL_A_W'(cap1);
                        mul_b      = alsp_pkg::MUL_B_W'(alsp_pkg::MICRO);
                        mul_n      = alsp_pkg::MUL_N_W'(20);
                        state_next = alsp_pkg::S_MUL_D1;
                    end
                    else
                        state_next = alsp_pkg::S_PERIOD;
                end
            end
            alsp_pkg::S_MUL_D1:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = alsp_pkg::MUL_A_W'(tick_reg);
                    mul_b      = alsp_pkg::MUL_B_W'(mag_reg);
                    mul_n      = alsp_pkg::MUL_N_W'(24);
                    state_next = alsp_pkg::S_MUL_P1;
                end
            end
            alsp_pkg::S_MUL_P1:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    div_num    = mul_prod << CHARGE_FRAC_BITS;
                    div_den    = d1_reg;
                    state_next = alsp_pkg::S_DIV1;
                end
            end
            alsp_pkg::S_DIV1:
            begin
                if (div_done)
                    state_next = upd_c ? alsp_pkg::S_PERIOD : alsp_pkg::S_DONE;
            end
            alsp_pkg::S_PERIOD:
            begin
                if (low_cur)
                    state_next = alsp_pkg::S_DONE;
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = alsp_pkg::MUL_A_W'(target_reg);
                    mul_b      = alsp_pkg::MUL_B_W'(alsp_pkg::MICRO);
                    mul_n      = alsp_pkg::MUL_N_W'(20);
                    state_next = alsp_pkg::S_MUL_T;
                end
            end
            alsp_pkg::S_MUL_T:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mul_prod[alsp_pkg::MUL_A_W-1:0];
                    mul_b      = cap_reg;
                    mul_n      = alsp_pkg::MUL_N_W'(40);
                    state_next = alsp_pkg::S_MUL_P2;
                end
            end
            alsp_pkg::S_MUL_P2:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    div_num    = mul_prod;
                    div_den    = alsp_pkg::DIV_D_W'(mag_reg) << CHARGE_FRAC_BITS;
                    state_next = alsp_pkg::S_DIV2;
                end
            end
            alsp_pkg::S_DIV2:
            begin
                if (div_done)
                    state_next = alsp_pkg::S_DONE;
            end
            alsp_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = alsp_pkg::S_IDLE;
                end
            end
            default:
                state_next = alsp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg           <= 40'd1;
            target_reg        <= '0;
            tick_reg          <= '0;
            maxp_reg          <= '0;
            thr_reg           <= '0;
            started_reg       <= 1'b0;
            last_current_reg  <= '0;
            last_period_reg   <= '0;
            last_interval_reg <= '0;
            charge_acc_reg    <= '0;
            elapsed_reg       <= '0;
            upd_reg           <= 1'b0;
            wake_reg          <= 1'b0;
            rising_reg        <= 1'b0;
            fall_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    alsp_pkg::REG_CAPACITY: cap_reg <= cfg_wdata;
                    alsp_pkg::REG_TARGET:   target_reg <= cfg_wdata[28:0];
                    alsp_pkg::REG_TICK:     tick_reg <= cfg_wdata[31:0];
                    alsp_pkg::REG_MAX_PER:
                    begin
                        maxp_reg        <= cfg_wdata[31:0];
                        last_period_reg <= cfg_wdata[31:0];
                    end
                    alsp_pkg::REG_LOW_THR:  thr_reg <= cfg_wdata[22:0];
                    alsp_pkg::REG_START_EL: elapsed_reg <= cfg_wdata[31:0];
                    default: ;
                endcase
            end

            if (accept)
            begin
                last_current_reg <= current_ua;
                rising_reg       <= in_rising;
                fall_reg         <= in_fall;
                wake_reg         <= started_reg && in_rising;
                upd_reg          <= !started_reg;
                started_reg      <= 1'b1;
            end

            if ((state_reg == alsp_pkg::S_DIV1) && div_done)
            begin
                elapsed_reg       <= el_c;
                charge_acc_reg    <= ch_c;
                last_interval_reg <= intv_c;
                upd_reg           <= upd_c;
            end

            if ((state_reg == alsp_pkg::S_PERIOD) && low_cur)
                last_period_reg <= maxp_reg;
            if ((state_reg == alsp_pkg::S_DIV2) && div_done)
                last_period_reg <= period_c;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_neg_reg <= current_ua[23];
            mag_reg     <= in_mag;
        end
        if ((state_reg == alsp_pkg::S_MUL_D1) && mul_done)
            d1_reg <= mul_prod[63:0];
        if (out_load)
        begin
            updated_reg      <= upd_reg;
            wakeup_reg       <= wake_reg;
            charge_out_reg   <= charge_acc_reg;
            interval_out_reg <= last_interval_reg;
            period_out_reg   <= last_period_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign updated         = updated_reg;
    assign wakeup          = wakeup_reg;
    assign charge_fraction = charge_out_reg;
    assign interval_us     = interval_out_reg;
    assign period_us       = period_out_reg;

endmodule

`default_nettype wire
